FILE: hdl/prt_pkg.sv
// prt_pkg: shared types and constants of the path resampler
// datapath command codes, controller status, register map, number widths
// no dependencies
package prt_pkg;

  localparam int DIV_W  = 66;
  localparam int DIVR_W = 34;
  localparam int SQ_W   = 64;
  localparam int ROOT_W = 32;

  localparam logic [15:0] MIN_SPEED_Q8 = 16'd3;
  localparam logic [15:0] QUAT_MAX     = 16'd32767;

  localparam logic [1:0] REG_CRUISE_SPEED = 2'd0;
  localparam logic [1:0] REG_STOP_MODE    = 2'd1;
  localparam logic [1:0] REG_HORIZON      = 2'd2;
  localparam logic [1:0] REG_SPACING      = 2'd3;

  localparam logic [15:0] RST_CRUISE_SPEED = 16'd2048;
  localparam logic [31:0] RST_HORIZON      = 32'd3276800;
  localparam logic [31:0] RST_SPACING      = 32'd65536;

  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_LOAD     = 5'd1;
  localparam logic [4:0] OP_RESTART  = 5'd2;
  localparam logic [4:0] OP_SQA      = 5'd3;
  localparam logic [4:0] OP_SQB      = 5'd4;
  localparam logic [4:0] OP_SQRT_LEN = 5'd5;
  localparam logic [4:0] OP_LEN      = 5'd6;
  localparam logic [4:0] OP_SKIP     = 5'd7;
  localparam logic [4:0] OP_DIV_W    = 5'd8;
  localparam logic [4:0] OP_DIV_Z    = 5'd9;
  localparam logic [4:0] OP_SQRT_Q   = 5'd10;
  localparam logic [4:0] OP_SET_W    = 5'd11;
  localparam logic [4:0] OP_SET_Z    = 5'd12;
  localparam logic [4:0] OP_MX       = 5'd13;
  localparam logic [4:0] OP_MY       = 5'd14;
  localparam logic [4:0] OP_DIV_PX   = 5'd15;
  localparam logic [4:0] OP_DIV_PY   = 5'd16;
  localparam logic [4:0] OP_SET_X    = 5'd17;
  localparam logic [4:0] OP_SET_Y    = 5'd18;
  localparam logic [4:0] OP_DIV_T    = 5'd19;
  localparam logic [4:0] OP_SET_T    = 5'd20;
  localparam logic [4:0] OP_EMIT     = 5'd21;
  localparam logic [4:0] OP_DIV_E    = 5'd22;
  localparam logic [4:0] OP_END      = 5'd23;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
    logic fresh;
    logic skip;
    logic last;
  } sts_t;

endpackage

FILE: hdl/prt_div.sv
// prt_div: restoring divider, one quotient bit per cycle
// depends on prt_pkg for widths
module prt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [prt_pkg::DIV_W-1:0]  dividend,
  input  logic [prt_pkg::DIVR_W-1:0] divisor,
  output logic                       busy,
  output logic [prt_pkg::DIV_W-1:0]  quot,
  output logic [prt_pkg::DIVR_W-1:0] rem
);
  import prt_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  dvd_r, q_r;
  logic [DIVR_W-1:0] r_r, d_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVR_W:0]   r_sh;
  logic              ge;

  assign r_sh = {r_r, dvd_r[DIV_W-1]};
  assign ge   = r_sh >= {1'b0, d_r};
  assign busy = cnt_r != '0;
  assign quot = q_r;
  assign rem  = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      d_r   <= divisor;
      r_r   <= '0;
      q_r   <= '0;
    end else if (busy) begin
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      r_r   <= ge ? DIVR_W'(r_sh - {1'b0, d_r}) : r_sh[DIVR_W-1:0];
      q_r   <= {q_r[DIV_W-2:0], ge};
    end
  end

endmodule

FILE: hdl/prt_sqrt.sv
// prt_sqrt: digit-by-digit integer square root, one result bit per cycle
// depends on prt_pkg for widths
module prt_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [prt_pkg::SQ_W-1:0]   radicand,
  output logic                       busy,
  output logic [prt_pkg::ROOT_W-1:0] root
);
  import prt_pkg::*;

  logic [SQ_W-1:0] v_r, r_r, bit_r, trial;
  logic            ge;

  assign trial = r_r + bit_r;
  assign ge    = v_r >= trial;
  assign busy  = |bit_r;
  assign root  = r_r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else if (start) begin
      bit_r <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy) begin
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= radicand;
      r_r <= '0;
    end else if (busy) begin
      if (ge) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
    end
  end

endmodule

FILE: hdl/prt_datapath.sv
// prt_datapath: segment geometry, point stepping, run state and result registers
// depends on prt_pkg, prt_div and prt_sqrt
module prt_datapath #(
  parameter int MAX_POINTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  prt_pkg::cmd_t       cmd,
  output prt_pkg::sts_t       sts,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic                in_path_start,
  input  logic [15:0]         cruise_speed,
  input  logic                stop_mode,
  input  logic [31:0]         horizon_lim,
  input  logic [31:0]         step_len,
  output logic signed [31:0]  out_point_x,
  output logic signed [31:0]  out_point_y,
  output logic signed [15:0]  out_quat_z,
  output logic signed [15:0]  out_quat_w,
  output logic [15:0]         out_point_speed,
  output logic [31:0]         out_time_offset,
  output logic                out_run_last,
  output logic                out_horizon_hit
);
  import prt_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic signed [31:0] cur_x_r, cur_y_r, prev_x_r, prev_y_r;
  logic               start_r, have_prev_r, hz_done_r, last_r;
  logic [31:0]        elapsed_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [63:0]        acc_r, prod_r;
  logic [32:0]        len_r;
  logic [15:0]        wq_r, zo_r;
  logic [33:0]        qsx_r, qsy_r, qx_r, qy_r, s_r;
  logic [32:0]        rsx_r, rsy_r, rx_r, ry_r;
  logic [41:0]        qst_r, qt_r;
  logic [15:0]        rst_r, rt_r;

  logic [32:0] dx, dy, ax, ay;
  logic        big;
  logic [31:0] mx, my, sp;
  logic [15:0] speed, v;
  logic [33:0] two_len, num_w, num_z;
  logic signed [34:0] nw, nz;

  logic              div_start, div_busy, sq_start, sq_busy;
  logic [DIV_W-1:0]  div_dvd, div_q;
  logic [DIVR_W-1:0] div_dvs, div_r;
  logic [SQ_W-1:0]   sq_rad;
  logic [ROOT_W-1:0] sq_root;
  logic [15:0]       qclamp;

  logic [CNT_W-1:0]       cnt_n;
  logic [CNT_W+31:0]      cnt_prod;
  logic                   hit, cap, last_n;
  logic [33:0]            s_n, rx_sum, ry_sum, rx_n, ry_n;
  logic                   gx, gy, gt;
  logic [16:0]            rt_sum;
  logic [15:0]            rt_n;
  logic [42:0]            tsum, esum;

  function automatic logic [33:0] clamp_num(input logic signed [34:0] n,
                                            input logic [33:0] lim);
    logic [33:0] res;
    if (n[34]) begin
      res = '0;
    end else if (n[33:0] > lim) begin
      res = lim;
    end else begin
      res = n[33:0];
    end
    return res;
  endfunction

  assign dx  = {cur_x_r[31], cur_x_r} - {prev_x_r[31], prev_x_r};
  assign dy  = {cur_y_r[31], cur_y_r} - {prev_y_r[31], prev_y_r};
  assign ax  = dx[32] ? 33'd0 - dx : dx;
  assign ay  = dy[32] ? 33'd0 - dy : dy;
  assign big = ax[32] | ax[31] | ay[32] | ay[31];
  assign mx  = big ? ax[32:1] : ax[31:0];
  assign my  = big ? ay[32:1] : ay[31:0];
  assign sp  = (step_len == '0) ? 32'd1 : step_len;
  assign speed = stop_mode ? 16'd0 : cruise_speed;
  assign v     = (speed > MIN_SPEED_Q8) ? speed : MIN_SPEED_Q8;

  assign two_len = {len_r, 1'b0};
  assign nw    = $signed({2'b00, len_r}) + $signed({{2{dx[32]}}, dx});
  assign nz    = $signed({2'b00, len_r}) - $signed({{2{dx[32]}}, dx});
  assign num_w = clamp_num(nw, two_len);
  assign num_z = clamp_num(nz, two_len);

  always_comb begin
    div_start = 1'b1;
    div_dvs   = {1'b0, len_r};
    case (cmd.op)
      OP_DIV_W:  div_dvd = {3'b000, num_w, 29'd0};
      OP_DIV_Z:  div_dvd = {3'b000, num_z, 29'd0};
      OP_DIV_PX: div_dvd = {2'b00, prod_r} + (ax[32] ? {2'b00, sp, 32'd0} : '0);
      OP_DIV_PY: div_dvd = {2'b00, prod_r} + (ay[32] ? {2'b00, sp, 32'd0} : '0);
      OP_DIV_T: begin
        div_dvd = {26'd0, sp, 8'd0};
        div_dvs = {18'd0, v};
      end
      OP_DIV_E: begin
        div_dvd = {25'd0, len_r, 8'd0};
        div_dvs = {18'd0, v};
      end
      default: begin
        div_dvd   = '0;
        div_start = 1'b0;
      end
    endcase
  end

  assign sq_start = (cmd.op == OP_SQRT_LEN) || (cmd.op == OP_SQRT_Q);
  assign sq_rad   = (cmd.op == OP_SQRT_LEN) ? acc_r : {33'd0, div_q[30:0]};
  assign qclamp   = (sq_root > 32'(QUAT_MAX)) ? QUAT_MAX : sq_root[15:0];

  prt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quot     (div_q),
    .rem      (div_r)
  );

  prt_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  assign cnt_n    = cnt_r + 1'b1;
  assign cnt_prod = cnt_n * step_len;
  assign hit      = cnt_prod > {{CNT_W{1'b0}}, horizon_lim};
  assign cap      = cnt_n >= CNT_W'(MAX_POINTS);
  assign s_n      = s_r + {2'b00, sp};
  assign last_n   = hit || cap || (s_n >= {1'b0, len_r});

  assign rx_sum = {1'b0, rx_r} + {1'b0, rsx_r};
  assign ry_sum = {1'b0, ry_r} + {1'b0, rsy_r};
  assign gx     = rx_sum >= {1'b0, len_r};
  assign gy     = ry_sum >= {1'b0, len_r};
  assign rx_n   = gx ? rx_sum - {1'b0, len_r} : rx_sum;
  assign ry_n   = gy ? ry_sum - {1'b0, len_r} : ry_sum;
  assign rt_sum = {1'b0, rt_r} + {1'b0, rst_r};
  assign gt     = rt_sum >= {1'b0, v};
  assign rt_n   = gt ? 16'(rt_sum - {1'b0, v}) : rt_sum[15:0];

  assign tsum = {11'd0, elapsed_r} + {1'b0, qt_r};
  assign esum = {11'd0, elapsed_r} + {1'b0, div_q[41:0]};

  assign sts.div_busy  = div_busy;
  assign sts.sqrt_busy = sq_busy;
  assign sts.fresh     = start_r | ~have_prev_r;
  assign sts.skip      = hz_done_r | (len_r == '0);
  assign sts.last      = last_r;

  // run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      hz_done_r   <= 1'b0;
      cnt_r       <= '0;
      elapsed_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
    end else begin
      case (cmd.op)
        OP_RESTART: begin
          prev_x_r    <= cur_x_r;
          prev_y_r    <= cur_y_r;
          have_prev_r <= 1'b1;
          hz_done_r   <= 1'b0;
          cnt_r       <= '0;
          elapsed_r   <= '0;
        end
        OP_SKIP: begin
          prev_x_r <= cur_x_r;
          prev_y_r <= cur_y_r;
        end
        OP_EMIT: begin
          cnt_r <= cnt_n;
          if (hit || cap) begin
            hz_done_r <= 1'b1;
          end
        end
        OP_END: begin
          prev_x_r  <= cur_x_r;
          prev_y_r  <= cur_y_r;
          elapsed_r <= esum[42:32] != '0 ? 32'hFFFF_FFFF : esum[31:0];
        end
        default: ;
      endcase
    end
  end

  // segment and point registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cur_x_r <= in_pos_x;
        cur_y_r <= in_pos_y;
        start_r <= in_path_start;
      end
      OP_SQA: acc_r <= mx * mx;
      OP_SQB: acc_r <= acc_r + my * my;
      OP_LEN: len_r <= big ? {sq_root, 1'b0} : {1'b0, sq_root};
      OP_SET_W: wq_r <= qclamp;
      OP_SET_Z: zo_r <= dy[32] ? 16'd0 - qclamp : qclamp;
      OP_MX: prod_r <= ax[31:0] * sp;
      OP_MY: prod_r <= ay[31:0] * sp;
      OP_SET_X: begin
        qsx_r <= div_q[33:0];
        rsx_r <= div_r[32:0];
      end
      OP_SET_Y: begin
        qsy_r <= div_q[33:0];
        rsy_r <= div_r[32:0];
      end
      OP_SET_T: begin
        qst_r <= div_q[41:0];
        rst_r <= div_r[15:0];
        s_r   <= '0;
        qx_r  <= '0;
        rx_r  <= '0;
        qy_r  <= '0;
        ry_r  <= '0;
        qt_r  <= '0;
        rt_r  <= '0;
      end
      OP_EMIT: begin
        out_point_x     <= dx[32] ? prev_x_r - $signed(qx_r[31:0])
                                  : prev_x_r + $signed(qx_r[31:0]);
        out_point_y     <= dy[32] ? prev_y_r - $signed(qy_r[31:0])
                                  : prev_y_r + $signed(qy_r[31:0]);
        out_quat_z      <= zo_r;
        out_quat_w      <= wq_r;
        out_point_speed <= speed;
        out_time_offset <= tsum[42:32] != '0 ? 32'hFFFF_FFFF : tsum[31:0];
        out_run_last    <= last_n;
        out_horizon_hit <= hit;
        last_r          <= last_n;
        s_r             <= s_n;
        qx_r            <= qx_r + qsx_r + {33'd0, gx};
        rx_r            <= rx_n[32:0];
        qy_r            <= qy_r + qsy_r + {33'd0, gy};
        ry_r            <= ry_n[32:0];
        qt_r            <= qt_r + qst_r + {41'd0, gt};
        rt_r            <= rt_n;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/prt_ctrl.sv
// prt_ctrl: sequencer for one waypoint, drives datapath commands and handshakes
// depends on prt_pkg
module prt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  prt_pkg::sts_t sts,
  output prt_pkg::cmd_t cmd
);
  import prt_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DEC  = 5'd1;
  localparam logic [4:0] S_SQB  = 5'd2;
  localparam logic [4:0] S_LSQ  = 5'd3;
  localparam logic [4:0] S_LW   = 5'd4;
  localparam logic [4:0] S_CHK  = 5'd5;
  localparam logic [4:0] S_WDW  = 5'd6;
  localparam logic [4:0] S_WSW  = 5'd7;
  localparam logic [4:0] S_ZD   = 5'd8;
  localparam logic [4:0] S_ZDW  = 5'd9;
  localparam logic [4:0] S_ZSW  = 5'd10;
  localparam logic [4:0] S_MX   = 5'd11;
  localparam logic [4:0] S_PXD  = 5'd12;
  localparam logic [4:0] S_PXW  = 5'd13;
  localparam logic [4:0] S_MY   = 5'd14;
  localparam logic [4:0] S_PYD  = 5'd15;
  localparam logic [4:0] S_PYW  = 5'd16;
  localparam logic [4:0] S_TD   = 5'd17;
  localparam logic [4:0] S_TW   = 5'd18;
  localparam logic [4:0] S_EMIT = 5'd19;
  localparam logic [4:0] S_OUT  = 5'd20;
  localparam logic [4:0] S_ED   = 5'd21;
  localparam logic [4:0] S_EW   = 5'd22;

  logic [4:0] state_r, state_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.fresh) begin
          cmd.op    = OP_RESTART;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_SQA;
          state_nxt = S_SQB;
        end
      end
      S_SQB: begin
        cmd.op    = OP_SQB;
        state_nxt = S_LSQ;
      end
      S_LSQ: begin
        cmd.op    = OP_SQRT_LEN;
        state_nxt = S_LW;
      end
      S_LW: begin
        if (!sts.sqrt_busy) begin
          cmd.op    = OP_LEN;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.skip) begin
          cmd.op    = OP_SKIP;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_DIV_W;
          state_nxt = S_WDW;
        end
      end
      S_WDW: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_SQRT_Q;
          state_nxt = S_WSW;
        end
      end
      S_WSW: begin
        if (!sts.sqrt_busy) begin
          cmd.op    = OP_SET_W;
          state_nxt = S_ZD;
        end
      end
      S_ZD: begin
        cmd.op    = OP_DIV_Z;
        state_nxt = S_ZDW;
      end
      S_ZDW: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_SQRT_Q;
          state_nxt = S_ZSW;
        end
      end
      S_ZSW: begin
        if (!sts.sqrt_busy) begin
          cmd.op    = OP_SET_Z;
          state_nxt = S_MX;
        end
      end
      S_MX: begin
        cmd.op    = OP_MX;
        state_nxt = S_PXD;
      end
      S_PXD: begin
        cmd.op    = OP_DIV_PX;
        state_nxt = S_PXW;
      end
      S_PXW: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_SET_X;
          state_nxt = S_MY;
        end
      end
      S_MY: begin
        cmd.op    = OP_MY;
        state_nxt = S_PYD;
      end
      S_PYD: begin
        cmd.op    = OP_DIV_PY;
        state_nxt = S_PYW;
      end
      S_PYW: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_SET_Y;
          state_nxt = S_TD;
        end
      end
      S_TD: begin
        cmd.op    = OP_DIV_T;
        state_nxt = S_TW;
      end
      S_TW: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_SET_T;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.op    = OP_EMIT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = sts.last ? S_ED : S_EMIT;
        end
      end
      S_ED: begin
        cmd.op    = OP_DIV_E;
        state_nxt = S_EW;
      end
      S_EW: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_END;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/path_resample_trajectory_core.sv
// path_resample_trajectory_core: top level of the path resampler
// holds the register file, joins prt_ctrl and prt_datapath; uses prt_pkg
//
//  channel  direction  handshake          payload
//  in_      request    in_valid/in_ready  pos_x, pos_y, path_start
//  out_     result     out_valid/out_ready point, quaternion, speed, time, flags
//  apb      config     psel/penable/pready registers at byte 0, 4, 8, 12
//
// a path start waypoint only restarts the path; a zero-length or horizon-done
// segment is skipped once its length is known; a segment runs setup (three square roots
// and five divisions in one shared divider), then emits points, each one held
// until out_ready, and updates elapsed time before the next request is taken
// synchronous active-low reset returns registers to defaults and clears path state
module path_resample_trajectory_core #(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic               in_path_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  output logic [15:0]        out_point_speed,
  output logic [31:0]        out_time_offset,
  output logic               out_run_last,
  output logic               out_horizon_hit,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import prt_pkg::*;

  logic [15:0]   cruise_speed_r;
  logic          stop_mode_r;
  logic [31:0]   horizon_r, spacing_r;
  logic          wr_en;
  prt_pkg::cmd_t cmd;
  prt_pkg::sts_t sts;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cruise_speed_r <= RST_CRUISE_SPEED;
      stop_mode_r    <= 1'b0;
      horizon_r      <= RST_HORIZON;
      spacing_r      <= RST_SPACING;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_CRUISE_SPEED: cruise_speed_r <= pwdata[15:0];
        REG_STOP_MODE:    stop_mode_r    <= pwdata[0];
        REG_HORIZON:      horizon_r      <= pwdata;
        REG_SPACING:      spacing_r      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CRUISE_SPEED: prdata = {16'd0, cruise_speed_r};
      REG_STOP_MODE:    prdata = {31'd0, stop_mode_r};
      REG_HORIZON:      prdata = horizon_r;
      REG_SPACING:      prdata = spacing_r;
      default:          prdata = '0;
    endcase
  end

  prt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  prt_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_path_start   (in_path_start),
    .cruise_speed    (cruise_speed_r),
    .stop_mode       (stop_mode_r),
    .horizon_lim     (horizon_r),
    .step_len        (spacing_r),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_quat_z      (out_quat_z),
    .out_quat_w      (out_quat_w),
    .out_point_speed (out_point_speed),
    .out_time_offset (out_time_offset),
    .out_run_last    (out_run_last),
    .out_horizon_hit (out_horizon_hit)
  );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for path_resample_trajectory_core
// waypoint requests in, checked trajectory points out, registers set over apb
// depends on prt_pkg and path_resample_trajectory_core
module tb;
  import prt_pkg::*;

  localparam int  CYCLE_LIMIT = 4000000;
  localparam int  SETTLE      = 600;
  localparam int  CAP         = 64;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] z;
    logic [15:0] w;
    logic [15:0] spd;
    logic [31:0] t;
    logic        last;
    logic        hit;
  } point_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        ps;
    int          n;
    logic [31:0] fx;
    logic [31:0] fy;
    int          fz;
    int          fw;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] in_pos_x = 0;
  logic signed [31:0] in_pos_y = 0;
  logic in_path_start = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] out_point_x, out_point_y;
  logic signed [15:0] out_quat_z, out_quat_w;
  logic [15:0] out_point_speed;
  logic [31:0] out_time_offset;
  logic out_run_last, out_horizon_hit;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  path_resample_trajectory_core u_dut (.*);

  always #5 clk = ~clk;

  // shadow registers and path state
  logic [15:0] r_speed;
  logic        r_stop;
  logic [31:0] r_horizon, r_spacing;
  logic signed [63:0] last_x, last_y;
  logic        seen_start;
  logic [63:0] run_time;
  int          run_count;
  logic        run_done;

  point_t expected_points[$];
  int     errors = 0;
  int     cycles = 0;
  int     send_idle = 0, recv_idle = 0, hold_cnt = 0;
  logic signed [31:0] walk_x = 0, walk_y = 0;

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] half_angle(input logic signed [63:0] len,
                                             input logic signed [63:0] num);
    logic [63:0] q;
    if (num < 0) num = 0;
    if (num > 2 * len) num = 2 * len;
    q = isqrt((64'(num) << 29) / 64'(len));
    return (q > 64'd32767) ? QUAT_MAX : q[15:0];
  endfunction

  function automatic logic [63:0] sat32(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
  endfunction

  function automatic void reset_path_state();
    r_speed = RST_CRUISE_SPEED;
    r_stop = 0;
    r_horizon = RST_HORIZON;
    r_spacing = RST_SPACING;
    last_x = 0;
    last_y = 0;
    seen_start = 0;
    run_time = 0;
    run_count = 0;
    run_done = 0;
  endfunction

  // expected points for one accepted waypoint; returns their number
  function automatic int resample_segment(input logic [31:0] px, input logic [31:0] py,
                                          input logic ps, output point_t first);
    logic signed [63:0] x, y, dx, dy, len, ox, oy;
    logic [63:0] ax, ay, spacing, v, s;
    logic [15:0] spd, wq, zq;
    point_t p;
    int n;
    logic hit;
    x = 64'($signed(px));
    y = 64'($signed(py));
    n = 0;
    first = '0;
    if (ps || !seen_start) begin
      last_x = x;
      last_y = y;
      seen_start = 1;
      run_time = 0;
      run_count = 0;
      run_done = 0;
      return 0;
    end
    dx = x - last_x;
    dy = y - last_y;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000)
      len = 2 * isqrt((ax >> 1) * (ax >> 1) + (ay >> 1) * (ay >> 1));
    else
      len = isqrt(ax * ax + ay * ay);
    if (run_done || len == 0) begin
      last_x = x;
      last_y = y;
      return 0;
    end
    spacing = (r_spacing != 0) ? 64'(r_spacing) : 64'd1;
    spd = r_stop ? 16'd0 : r_speed;
    v = (spd > MIN_SPEED_Q8) ? 64'(spd) : 64'(MIN_SPEED_Q8);
    wq = half_angle(len, len + dx);
    zq = half_angle(len, len - dx);
    if (dy < 0) zq = -zq;
    for (s = 0; s < 64'(len); s = s + spacing) begin
      ox = 64'(({64'd0, ax} * {64'd0, s}) / {64'd0, 64'(len)});
      oy = 64'(({64'd0, ay} * {64'd0, s}) / {64'd0, 64'(len)});
      p.x = (dx < 0) ? 32'(last_x - ox) : 32'(last_x + ox);
      p.y = (dy < 0) ? 32'(last_y - oy) : 32'(last_y + oy);
      p.z = zq;
      p.w = wq;
      p.spd = spd;
      p.t = 32'(sat32(run_time, (s << 8) / v));
      p.last = 0;
      run_count++;
      hit = (64'(run_count) * 64'(r_spacing)) > 64'(r_horizon);
      p.hit = hit;
      if (n == 0) first = p;
      expected_points = {expected_points, p};
      n++;
      if (hit || run_count >= CAP) begin
        run_done = 1;
        break;
      end
    end
    run_time = sat32(run_time, (64'(len) << 8) / v);
    last_x = x;
    last_y = y;
    if (n > 0) expected_points[$].last = 1;
    return n;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  // result side
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready = 0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    point_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_point_x, out_point_y, out_quat_z, out_quat_w, out_point_speed,
              out_time_offset, out_run_last, out_horizon_hit};
      if (expected_points.size() == 0) begin
        flag_error($sformatf("unexpected point %h", got));
      end else begin
        want = expected_points.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.w !== want.w || got.spd !== want.spd || got.t !== want.t ||
            got.last !== want.last || got.hit !== want.hit)
          flag_error($sformatf({"exp x=%h y=%h z=%h w=%h v=%h t=%h l=%b h=%b ",
                                "got x=%h y=%h z=%h w=%h v=%h t=%h l=%b h=%b"},
            want.x, want.y, want.z, want.w, want.spd, want.t, want.last, want.hit,
            got.x, got.y, got.z, got.w, got.spd, got.t, got.last, got.hit));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic send_request(input logic [31:0] x, input logic [31:0] y, input logic ps,
                              output int n, output point_t first);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_pos_x = x;
    in_pos_y = y;
    in_path_start = ps;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = resample_segment(x, y, ps, first);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
    case (idx)
      REG_CRUISE_SPEED: r_speed = val[15:0];
      REG_STOP_MODE:    r_stop = val[0];
      REG_HORIZON:      r_horizon = val;
      default:          r_spacing = val;
    endcase
  endtask

  task automatic next_waypoint(output logic [31:0] x, output logic [31:0] y,
                               output logic ps);
    int mode;
    mode = $urandom_range(9);
    ps = ($urandom_range(7) == 0);
    if (mode == 0) begin
      walk_x = $urandom;
      walk_y = $urandom;
    end else begin
      walk_x = walk_x + ($signed(32'($urandom_range(0, 32'h80000))) - 32'sh40000);
      walk_y = walk_y + ($signed(32'($urandom_range(0, 32'h80000))) - 32'sh40000);
    end
    x = walk_x;
    y = walk_y;
  endtask

  row_t rows[] = '{
    '{32'h0, 32'h0, 1'b0, 0, 0, 0, -1, -1},
    '{32'd196608, 32'h0, 1'b0, 3, 32'h0, 32'h0, 0, 32767},
    '{32'd196608, 32'h0, 1'b0, 0, 0, 0, -1, -1},
    '{32'h0, 32'h0, 1'b0, 3, 32'd196608, 32'h0, 32767, 0},
    '{32'h0, -32'sd131072, 1'b0, 2, 32'h0, 32'h0, 16'hA57E, 23170},
    '{32'h0, -32'sd131072, 1'b1, 0, 0, 0, -1, -1},
    '{32'd65536, 32'd65536, 1'b0, -1, 0, 0, -1, -1},
    '{32'h7FFFFFFF, 32'h80000000, 1'b1, 0, 0, 0, -1, -1},
    '{32'h80000000, 32'h7FFFFFFF, 1'b0, 51, 32'h7FFFFFFF, 32'h80000000, -1, -1},
    '{32'h0, 32'h0, 1'b0, 0, 0, 0, -1, -1},
    '{32'h0, 32'h0, 1'b1, 0, 0, 0, -1, -1},
    '{32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 51, 32'h0, 32'h0, -1, -1},
    '{32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 0, 0, 0, -1, -1},
    '{32'h7FFEFFFF, 32'h7FFFFFFF, 1'b0, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32767, 0}
  };

  logic [15:0] ph_speed[6]   = '{16'd2048, 16'd0, 16'd65535, 16'd256, 16'd3, 16'd1000};
  logic        ph_stop[6]    = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  logic [31:0] ph_horizon[6] = '{32'd3276800, 32'hFFFFFFFF, 32'd0, 32'd655360,
                                 32'd1000000, 32'hFFFFFFFF};
  logic [31:0] ph_spacing[6] = '{32'd65536, 32'd1, 32'hFFFFFFFF, 32'd32768,
                                 32'd0, 32'd131072};

  initial begin
    int n;
    point_t first;
    logic [31:0] x, y;
    logic ps;
    reset_path_state();
    repeat (10) @(negedge clk);
    rst_n = 1;
    send_idle = 29;
    recv_idle = 84;
    foreach (rows[i]) begin
      send_request(rows[i].x, rows[i].y, rows[i].ps, n, first);
      if (rows[i].n >= 0 && n != rows[i].n)
        flag_error($sformatf("row %0d gives %0d points, table says %0d", i, n, rows[i].n));
      if (rows[i].n > 0 && (first.x !== rows[i].fx || first.y !== rows[i].fy))
        flag_error($sformatf("row %0d first point %h %h", i, first.x, first.y));
      if (rows[i].fz >= 0 && (first.z !== 16'(rows[i].fz) || first.w !== 16'(rows[i].fw)))
        flag_error($sformatf("row %0d quaternion %h %h", i, first.z, first.w));
    end
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      repeat (SETTLE) @(posedge clk);
      reg_write(REG_CRUISE_SPEED, 32'(ph_speed[ph]));
      reg_write(REG_STOP_MODE, 32'(ph_stop[ph]));
      reg_write(REG_HORIZON, ph_horizon[ph]);
      reg_write(REG_SPACING, ph_spacing[ph]);
      send_idle = (ph < 2) ? 29 : (ph < 4) ? 84 : 0;
      recv_idle = (ph < 2) ? 84 : (ph < 4) ? 29 : 0;
      for (int k = 0; k < 70; k++) begin
        if (k == 35 && ph == 0) hold_cnt = 3000;
        if (k == 35 && ph == 3) drain();
        next_waypoint(x, y, ps);
        send_request(x, y, ps, n, first);
      end
    end
    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
